### design/wgm_pkg.sv
// wgm_pkg: shared types and constants for the wildcard glob matcher
// holds command codes, element kinds, character constants and the front-to-back request
// no dependencies
package wgm_pkg;

  localparam int PAT_MAX     = 63;
  localparam int IDX_W       = $clog2(PAT_MAX + 1);
  localparam int ACT_W       = PAT_MAX + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_EMPTY   = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_ANY  = 2'd1;
  localparam logic [1:0] KIND_STAR = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_TEXT  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } elem_t;

  typedef struct packed {
    logic       clear;
    logic [1:0] npush;
    elem_t      e0;
    elem_t      e1;
    logic [1:0] act_kind;
    logic       first;
    logic       last;
    logic [7:0] ch;
  } op_t;

endpackage

### design/wgm_front.sv
// wgm_front: accepts items, folds case when configured, decodes escapes into pattern elements
// builds one request per item, none for command 3, for the back end; depends on wgm_pkg
module wgm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       command,
  input  logic [7:0]       char_code,
  input  logic             last,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output wgm_pkg::op_t     q_op,
  output logic             accept
);
  import wgm_pkg::*;

  logic       exact_case;
  logic       loading;
  logic       loading_next;
  logic       bp;
  logic       bp_next;
  logic       bp_mid;
  logic       text_running;
  logic       text_running_next;
  logic [7:0] c_fold;
  op_t        op;

  assign accept = in_valid && !q_full;
  assign q_push = accept && (command != CMD_NONE);
  assign q_op   = op;

  always_comb begin
    c_fold = char_code;
    if (!exact_case && char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      c_fold = char_code + CASE_OFFSET;
    end
    op                = '0;
    op.ch             = c_fold;
    op.last           = last;
    op.act_kind       = OP_NONE;
    loading_next      = loading;
    bp_next           = bp;
    bp_mid            = 1'b0;
    text_running_next = text_running;
    unique case (command)
      CMD_PATTERN: begin
        op.clear = !loading;
        if (loading && bp) begin
          if (c_fold == CH_STAR || c_fold == CH_QUEST) begin
            op.npush = 2'd1;
            op.e0    = '{kind: KIND_LIT, ch: c_fold};
          end else if (c_fold == CH_BSLASH) begin
            op.npush = 2'd1;
            op.e0    = '{kind: KIND_LIT, ch: CH_BSLASH};
            bp_mid   = 1'b1;
          end else begin
            op.npush = 2'd2;
            op.e0    = '{kind: KIND_LIT, ch: CH_BSLASH};
            op.e1    = '{kind: KIND_LIT, ch: c_fold};
          end
        end else if (c_fold == CH_STAR) begin
          op.npush = 2'd1;
          op.e0    = '{kind: KIND_STAR, ch: 8'h00};
        end else if (c_fold == CH_QUEST) begin
          op.npush = 2'd1;
          op.e0    = '{kind: KIND_ANY, ch: 8'h00};
        end else if (c_fold == CH_BSLASH) begin
          bp_mid = 1'b1;
        end else begin
          op.npush = 2'd1;
          op.e0    = '{kind: KIND_LIT, ch: c_fold};
        end
        // trailing backslash closes as a literal
        if (last && bp_mid) begin
          if (op.npush == 2'd0) begin
            op.e0 = '{kind: KIND_LIT, ch: CH_BSLASH};
          end else begin
            op.e1 = '{kind: KIND_LIT, ch: CH_BSLASH};
          end
          op.npush = op.npush + 2'd1;
        end
        bp_next           = last ? 1'b0 : bp_mid;
        loading_next      = !last;
        text_running_next = 1'b0;
      end
      CMD_TEXT: begin
        if (loading && bp) begin
          op.npush = 2'd1;
          op.e0    = '{kind: KIND_LIT, ch: CH_BSLASH};
        end
        loading_next      = 1'b0;
        bp_next           = 1'b0;
        op.act_kind       = OP_TEXT;
        op.first          = !text_running;
        text_running_next = !last;
      end
      CMD_EMPTY: begin
        if (loading && bp) begin
          op.npush = 2'd1;
          op.e0    = '{kind: KIND_LIT, ch: CH_BSLASH};
        end
        loading_next      = 1'b0;
        bp_next           = 1'b0;
        op.act_kind       = OP_EMPTY;
        text_running_next = 1'b0;
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exact_case   <= 1'b1;
      loading      <= 1'b0;
      bp           <= 1'b0;
      text_running <= 1'b0;
    end else begin
      if (cfg_valid) begin
        exact_case <= cfg_data;
      end
      if (accept) begin
        loading      <= loading_next;
        bp           <= bp_next;
        text_running <= text_running_next;
      end
    end
  end

endmodule

### design/wgm_queue.sv
// wgm_queue: short request queue between front and back end
// four entries of wgm_pkg::op_t; depends on wgm_pkg
module wgm_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  input  wgm_pkg::op_t wr_data,
  output logic         full,
  output logic         rd_valid,
  output wgm_pkg::op_t rd_data,
  input  logic         rd_take
);
  import wgm_pkg::*;

  op_t                q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_wr;
  logic               do_rd;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = q_mem[rd_ptr];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/wgm_back.sv
// wgm_back: pattern element store and parallel active-position update
// runs of stars are spread with one wide add; holds the result register; depends on wgm_pkg
module wgm_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  wgm_pkg::op_t op,
  output logic         op_take,
  output logic         res_valid,
  output logic         res_matched,
  output logic         res_overflow,
  input  logic         res_pop
);
  import wgm_pkg::*;

  logic [1:0]       kind_r [PAT_MAX];
  logic [7:0]       lit_r  [PAT_MAX];
  logic [1:0]       kind_v [PAT_MAX];
  logic [7:0]       lit_v  [PAT_MAX];
  logic [IDX_W-1:0] len;
  logic             ovf;
  logic [ACT_W-1:0] lead;
  logic [ACT_W-1:0] act;

  logic [IDX_W-1:0] len0, len1, len2;
  logic             ovf0, ovf1, ovf2;
  logic [ACT_W-1:0] lead0, lead1, lead2;
  logic             we0, we1;
  logic [ACT_W-1:0] star_mask;
  logic [ACT_W-1:0] start;
  logic [ACT_W-1:0] nxt;
  logic [ACT_W-1:0] seed;
  logic [ACT_W-1:0] spread;
  logic [ACT_W-1:0] act_next;
  logic             res_gen;
  logic             hit;

  assign res_gen = (op.act_kind == OP_EMPTY) || (op.act_kind == OP_TEXT && op.last);
  assign op_take = op_valid && (!res_gen || !res_valid || res_pop);

  always_comb begin
    len0  = op.clear ? '0 : len;
    ovf0  = op.clear ? 1'b0 : ovf;
    lead0 = op.clear ? ACT_W'(1) : lead;

    we0   = (op.npush != 2'd0) && (len0 != IDX_W'(PAT_MAX));
    ovf1  = ovf0 || ((op.npush != 2'd0) && (len0 == IDX_W'(PAT_MAX)));
    lead1 = lead0;
    if (we0 && lead0[len0] && op.e0.kind == KIND_STAR) begin
      lead1[len0 + IDX_W'(1)] = 1'b1;
    end
    len1 = len0 + IDX_W'(we0);

    we1   = (op.npush == 2'd2) && (len1 != IDX_W'(PAT_MAX));
    ovf2  = ovf1 || ((op.npush == 2'd2) && (len1 == IDX_W'(PAT_MAX)));
    lead2 = lead1;
    if (we1 && lead1[len1] && op.e1.kind == KIND_STAR) begin
      lead2[len1 + IDX_W'(1)] = 1'b1;
    end
    len2 = len1 + IDX_W'(we1);
  end

  always_comb begin
    star_mask = '0;
    for (int i = 0; i < PAT_MAX; i++) begin
      if (we1 && len1 == IDX_W'(i)) begin
        kind_v[i] = op.e1.kind;
        lit_v[i]  = op.e1.ch;
      end else if (we0 && len0 == IDX_W'(i)) begin
        kind_v[i] = op.e0.kind;
        lit_v[i]  = op.e0.ch;
      end else begin
        kind_v[i] = kind_r[i];
        lit_v[i]  = lit_r[i];
      end
      star_mask[i] = (kind_v[i] == KIND_STAR) && (IDX_W'(i) < len2);
    end
  end

  always_comb begin
    start = op.first ? lead2 : act;
    nxt   = '0;
    for (int i = 0; i < PAT_MAX; i++) begin
      if (start[i] && IDX_W'(i) < len2) begin
        if (kind_v[i] == KIND_STAR) begin
          nxt[i] = 1'b1;
        end else if (kind_v[i] == KIND_ANY ||
                     (kind_v[i] == KIND_LIT && lit_v[i] == op.ch)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    // carries run through each star run from its first active bit
    seed   = nxt & star_mask;
    spread = (star_mask + seed) ^ star_mask ^ seed;
    case (op.act_kind)
      OP_TEXT:  act_next = nxt | spread;
      OP_EMPTY: act_next = lead2;
      default:  act_next = act;
    endcase
    hit = act_next[len2];
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      for (int i = 0; i < PAT_MAX; i++) begin
        kind_r[i] <= kind_v[i];
        lit_r[i]  <= lit_v[i];
      end
    end
    if (op_take && res_gen) begin
      res_matched  <= hit && !ovf2;
      res_overflow <= ovf2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ovf       <= 1'b0;
      lead      <= ACT_W'(1);
      act       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (op_take) begin
        len  <= len2;
        ovf  <= ovf2;
        lead <= lead2;
        act  <= act_next;
      end
      if (op_take && res_gen) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### design/wildcard_glob_matcher_unit.sv
// wildcard_glob_matcher_unit: top level of the glob matcher
// connects wgm_front, wgm_queue and wgm_back; depends on wgm_pkg

// Glob matcher for '*' and '?' with backslash escapes, pattern of up to 63 elements.
// Pattern bytes (command 0) and text bytes (command 1) are decoded into requests: a new
// request can be pushed every clock while the four-entry queue between the decoder
// and the matcher has room. The matcher updates every pattern position at once per
// text byte, with one 64-bit add to carry activity across runs of stars, so the
// sustained rate is one byte per cycle while finished results are popped. The last
// text byte (or empty-text request) of a result goes through the queue into the result
// register, where the result stays until popped; while it waits, further requests keep
// entering until the queue fills. There is no clearing pass after reset.
module wildcard_glob_matcher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command,
  input  logic [7:0] char_code,
  input  logic       last,
  output logic       empty,
  input  logic       pop,
  output logic       matched,
  output logic       pattern_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import wgm_pkg::*;

  logic q_full;
  logic q_push;
  op_t  q_in;
  logic q_valid;
  op_t  q_out;
  logic q_take;
  logic accept;
  logic res_valid;

  assign full      = q_full;
  assign empty     = !res_valid;
  assign cfg_ready = 1'b1;

  wgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .command   (command),
    .char_code (char_code),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_in),
    .accept    (accept)
  );

  wgm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_push),
    .wr_data  (q_in),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_out),
    .rd_take  (q_take)
  );

  wgm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op           (q_out),
    .op_take      (q_take),
    .res_valid    (res_valid),
    .res_matched  (matched),
    .res_overflow (pattern_overflow),
    .res_pop      (pop)
  );

`ifndef SYNTHESIS
  a_no_match_on_overflow: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(matched && pattern_overflow))
    else $error("match reported with pattern overflow");

  a_full_after_request: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(q_push))
    else $error("queue filled without a request");

  a_accept_only_with_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> !q_full)
    else $error("request accepted while queue full");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> empty && !full)
    else $error("not idle after reset");
`endif

endmodule
